### rtl/core/cscan_pkg.sv
// Shared types and constants for the circular-scan disk scheduler.
package cscan_pkg;

  localparam int CYL_W  = 12;
  localparam int TOT_W  = 14;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam logic [TOT_W-1:0] TOTAL_MAX      = 14'h3FFF;
  localparam logic             MOVE_HIGH_INIT = 1'b1;
  localparam logic [CYL_W-1:0] LAST_CYL_INIT  = 12'd199;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_START = 1'b1;

  localparam logic REG_MOVE_HIGH = 1'b0;
  localparam logic REG_LAST_CYL  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEEK,
    ST_FIRST,
    ST_EDGE1,
    ST_EDGE2,
    ST_SECOND
  } state_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_ROT_LEFT,
    OP_ROT_RIGHT
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [CYL_W-1:0] ins_cyl;
  } chain_ctrl_t;

  typedef struct packed {
    logic valid;
    logic first_free;
    logic tail;
  } cell_pos_t;

endpackage

### rtl/core/cscan_cell.sv
// One cell of the sorted request row: holds a cylinder and trades it with its neighbors.
module cscan_cell (
  input  logic                         clk,
  input  cscan_pkg::chain_ctrl_t       ctrl,
  input  cscan_pkg::cell_pos_t         pos,
  input  logic [cscan_pkg::CYL_W-1:0]  prev_val,
  input  logic                         prev_gt,
  input  logic [cscan_pkg::CYL_W-1:0]  next_val,
  input  logic [cscan_pkg::CYL_W-1:0]  wrap_val,
  output logic [cscan_pkg::CYL_W-1:0]  val,
  output logic                         gt
);
  import cscan_pkg::*;

  logic [CYL_W-1:0] val_next;

  assign gt = pos.valid && (val > ctrl.ins_cyl);

  always_comb begin
    val_next = val;
    case (ctrl.op)
      OP_INSERT: begin
        if (gt || pos.first_free) begin
          val_next = prev_gt ? prev_val : ctrl.ins_cyl;
        end
      end
      OP_ROT_LEFT: begin
        if (pos.valid) begin
          val_next = pos.tail ? wrap_val : next_val;
        end
      end
      OP_ROT_RIGHT: begin
        if (pos.valid) begin
          val_next = prev_val;
        end
      end
      default: begin
        val_next = val;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

### rtl/core/cscan_chain.sv
// Row of request cells kept in ascending order, with the low and high ends exposed.
module cscan_chain #(
  parameter int MAX_REQUESTS = 32
) (
  input  logic                                  clk,
  input  cscan_pkg::chain_ctrl_t                ctrl,
  input  logic [$clog2(MAX_REQUESTS+1)-1:0]     count,
  output logic [cscan_pkg::CYL_W-1:0]           front_low,
  output logic [cscan_pkg::CYL_W-1:0]           front_high
);
  import cscan_pkg::*;

  localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
  localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

  logic [CYL_W-1:0] vals [MAX_REQUESTS];
  logic             gts  [MAX_REQUESTS];
  logic [CNT_W-1:0] top_idx;

  assign top_idx    = count - CNT_W'(1);
  assign front_high = vals[top_idx[IDX_W-1:0]];
  assign front_low  = vals[0];

  for (genvar i = 0; i < MAX_REQUESTS; i++) begin : g_cell
    cell_pos_t        pos;
    logic [CYL_W-1:0] prev_val;
    logic             prev_gt;
    logic [CYL_W-1:0] next_val;

    assign pos.valid      = CNT_W'(i) < count;
    assign pos.first_free = CNT_W'(i) == count;
    assign pos.tail       = CNT_W'(i + 1) == count;

    if (i == 0) begin : g_head
      assign prev_val = front_high;
      assign prev_gt  = 1'b0;
    end else begin : g_body
      assign prev_val = vals[i-1];
      assign prev_gt  = gts[i-1];
    end

    if (i == MAX_REQUESTS - 1) begin : g_end
      assign next_val = '0;
    end else begin : g_mid
      assign next_val = vals[i+1];
    end

    cscan_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .pos      (pos),
      .prev_val (prev_val),
      .prev_gt  (prev_gt),
      .next_val (next_val),
      .wrap_val (vals[0]),
      .val      (vals[i]),
      .gt       (gts[i])
    );
  end

endmodule

### rtl/core/cscan_disk_scheduler_core.sv
// Circular-scan disk scheduler top level: control sequencer, register port and result word.
// A load word is taken while idle; the input stalls while a run is in progress.
// A start word first rotates the cell row once per request behind the head in the sweep
// direction (up to the request count), then emits one result word per cycle while the output
// is not stalled: count + 2 words in all.
// Synchronous reset empties the request row and restores move_high = 1, last_cylinder = 199.
module cscan_disk_scheduler_core #(
  parameter int MAX_REQUESTS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          kind,
  input  logic [cscan_pkg::CYL_W-1:0]   cylinder,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cscan_pkg::CYL_W-1:0]   position,
  output logic [cscan_pkg::TOT_W-1:0]   movement_total,
  output logic                          is_last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cscan_pkg::ADDR_W-1:0]  paddr,
  input  logic [cscan_pkg::DATA_W-1:0]  pwdata,
  output logic [cscan_pkg::DATA_W-1:0]  prdata,
  output logic                          pready
);
  import cscan_pkg::*;

  localparam int CNT_W = $clog2(MAX_REQUESTS + 1);

  state_t           state, state_next;
  chain_ctrl_t      ctrl;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] rot, rot_next;
  logic [CNT_W-1:0] left, left_next;
  logic [CYL_W-1:0] head, head_next;
  logic [TOT_W-1:0] total, total_next;
  logic             move_high;
  logic [CYL_W-1:0] last_cylinder;
  logic [CYL_W-1:0] front_low, front_high, front;
  logic             in_acc, adv, emit, emit_last;
  logic [CYL_W-1:0] emit_pos;
  logic [CYL_W-1:0] gap;
  logic [TOT_W:0]   sum;
  cell_op_t         rot_op;
  logic             cfg_wr;

  // Register port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      move_high     <= MOVE_HIGH_INIT;
      last_cylinder <= LAST_CYL_INIT;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_MOVE_HIGH: move_high     <= pwdata[0];
        REG_LAST_CYL:  last_cylinder <= pwdata[CYL_W-1:0];
        default:       move_high     <= move_high;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MOVE_HIGH: prdata = {{(DATA_W-1){1'b0}}, move_high};
      REG_LAST_CYL:  prdata = {{(DATA_W-CYL_W){1'b0}}, last_cylinder};
      default:       prdata = '0;
    endcase
  end

  cscan_chain #(
    .MAX_REQUESTS (MAX_REQUESTS)
  ) u_chain (
    .clk        (clk),
    .ctrl       (ctrl),
    .count      (count),
    .front_low  (front_low),
    .front_high (front_high)
  );

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign adv      = !out_valid || !out_stall;
  assign front    = move_high ? front_low : front_high;
  assign rot_op   = move_high ? OP_ROT_LEFT : OP_ROT_RIGHT;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    rot   <= rot_next;
    left  <= left_next;
    head  <= head_next;
    total <= total_next;
  end

  always_comb begin
    state_next   = state;
    ctrl.op      = OP_HOLD;
    ctrl.ins_cyl = cylinder;
    count_next   = count;
    rot_next     = rot;
    left_next    = left;
    head_next    = head;
    total_next   = total;
    emit         = 1'b0;
    emit_pos     = front;
    emit_last    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (kind == KIND_START) begin
            state_next = ST_SEEK;
            head_next  = cylinder;
            total_next = '0;
            rot_next   = '0;
          end else if (count < CNT_W'(MAX_REQUESTS)) begin
            ctrl.op    = OP_INSERT;
            count_next = count + CNT_W'(1);
          end
        end
      end
      ST_SEEK: begin
        if ((rot < count) && (move_high ? (front < head) : (front >= head))) begin
          ctrl.op  = rot_op;
          rot_next = rot + CNT_W'(1);
        end else begin
          left_next  = count - rot;
          state_next = (count != rot) ? ST_FIRST : ST_EDGE1;
        end
      end
      ST_FIRST: begin
        if (adv) begin
          emit      = 1'b1;
          ctrl.op   = rot_op;
          left_next = left - CNT_W'(1);
          if (left == CNT_W'(1)) begin
            state_next = ST_EDGE1;
          end
        end
      end
      ST_EDGE1: begin
        if (adv) begin
          emit       = 1'b1;
          emit_pos   = move_high ? last_cylinder : '0;
          state_next = ST_EDGE2;
        end
      end
      ST_EDGE2: begin
        if (adv) begin
          emit     = 1'b1;
          emit_pos = move_high ? '0 : last_cylinder;
          if (rot == '0) begin
            emit_last  = 1'b1;
            count_next = '0;
            state_next = ST_IDLE;
          end else begin
            left_next  = rot;
            state_next = ST_SECOND;
          end
        end
      end
      ST_SECOND: begin
        if (adv) begin
          emit      = 1'b1;
          ctrl.op   = rot_op;
          left_next = left - CNT_W'(1);
          if (left == CNT_W'(1)) begin
            emit_last  = 1'b1;
            count_next = '0;
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    gap = (head > emit_pos) ? (head - emit_pos) : (emit_pos - head);
    sum = {1'b0, total} + (TOT_W + 1)'(gap);
    if (emit) begin
      head_next  = emit_pos;
      total_next = (sum > (TOT_W + 1)'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOT_W-1:0];
    end
  end

  // Result word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      position       <= emit_pos;
      movement_total <= total_next;
      is_last        <= emit_last;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_REQUESTS))
    else $error("request count exceeds the store size");

  a_start_seek: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && kind == KIND_START) |=> (state == ST_SEEK))
    else $error("start word did not begin the search");

  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (emit && emit_last) |=> (state == ST_IDLE && count == '0 && out_valid && is_last))
    else $error("final word did not close the run");

  a_rot_bound: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (rot <= count))
    else $error("rotation count passed the request count");

  a_left_live: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIRST || state == ST_SECOND) |-> (left != '0))
    else $error("emit phase entered with nothing left");
`endif

endmodule
